// File: sv/nm3i_pkg.sv
package nm3i_pkg;

  localparam int DATA_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int NORM_FRAC  = 30;
  localparam int THR_W      = 31;
  localparam int SQRT_STEPS = 32;
  localparam int ND_STEPS   = 31;
  localparam int T_STEPS    = 48;
  localparam int Q_STEPS    = 32;
  localparam int SC_LAST    = T_STEPS + Q_STEPS + 1;
  localparam int ADJ_W      = 33;
  localparam int DMAG_W     = 34;

  localparam logic [DATA_W-1:0] POS_LIM = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] NEG_LIM = {1'b1, {(DATA_W-1){1'b0}}};

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_AFFINE = 3'd1;
  localparam logic [2:0] ST_ZERO_COL   = 3'd2;
  localparam logic [2:0] ST_SINGULAR   = 3'd3;
  localparam logic [2:0] ST_SAT        = 3'd4;

  typedef logic signed [DATA_W-1:0] ent_t;

  typedef struct packed {
    ent_t m00; ent_t m01; ent_t m02;
    ent_t m10; ent_t m11; ent_t m12;
    ent_t m20; ent_t m21; ent_t m22;
    logic affine_bottom_row;
  } in_item_t;

  typedef struct packed {
    ent_t inv00; ent_t inv01; ent_t inv02;
    ent_t inv10; ent_t inv11; ent_t inv12;
    ent_t inv20; ent_t inv21; ent_t inv22;
    logic [2:0] status;
  } out_item_t;

  // restoring divider state
  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] dv;
    logic [47:0] q;
  } div_t;

  typedef struct packed {
    logic [8:0][DATA_W-1:0] mag;
    logic [8:0]             neg;
    logic                   affine;
  } mat_info_t;

  typedef struct packed {
    mat_info_t              info;
    logic [2:0][DATA_W-1:0] norm;
  } norm_item_t;

  typedef struct packed {
    logic [8:0][DATA_W-1:0] a;
    logic [2:0][DATA_W-1:0] norm;
    logic                   affine;
    logic                   zero;
  } ndiv_item_t;

  typedef struct packed {
    logic [8:0][ADJ_W-1:0]  adj;
    logic                   dneg;
    logic [DMAG_W-1:0]      dmag;
    logic [2:0][DATA_W-1:0] norm;
    logic                   affine;
    logic                   zero;
    logic                   singular;
  } adj_item_t;

  // one quotient bit of a restoring division
  function automatic div_t div_step(input div_t s, input logic [63:0] d, input logic nb);
    logic [64:0] t;
    div_t        r;
    t = {s.rem, nb};
    r = s;
    if (t >= {1'b0, d}) begin
      r.rem = 64'(t - {1'b0, d});
      r.q   = {s.q[46:0], 1'b1};
    end else begin
      r.rem = t[63:0];
      r.q   = {s.q[46:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// File: sv/nm3i_norm.sv
module nm3i_norm import nm3i_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_vld,
  input  in_item_t   in_item,
  output logic       out_vld,
  output norm_item_t out_item
);

  logic [8:0][DATA_W-1:0] m_c;
  logic [8:0][DATA_W-1:0] mag_c;
  logic [8:0]             neg_c;

  logic                   s0_vld_r;
  mat_info_t              s0_info_r;
  logic [8:0][63:0]       s0_sq_r;

  logic [SQRT_STEPS:0]    vld_r;
  logic [SQRT_STEPS:0]    vld_nxt;
  mat_info_t              info_r   [SQRT_STEPS+1];
  mat_info_t              info_nxt [SQRT_STEPS+1];
  logic [2:0][63:0]       x_r      [SQRT_STEPS+1];
  logic [2:0][63:0]       x_nxt    [SQRT_STEPS+1];
  logic [2:0][63:0]       res_r    [SQRT_STEPS+1];
  logic [2:0][63:0]       res_nxt  [SQRT_STEPS+1];

  // entries in row-major order, split into sign and magnitude
  assign m_c = {in_item.m22, in_item.m21, in_item.m20,
                in_item.m12, in_item.m11, in_item.m10,
                in_item.m02, in_item.m01, in_item.m00};

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      neg_c[i] = m_c[i][DATA_W-1];
      mag_c[i] = m_c[i][DATA_W-1] ? (~m_c[i] + 1'b1) : m_c[i];
    end
  end

  // squares
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_info_r.mag    <= mag_c;
      s0_info_r.neg    <= neg_c;
      s0_info_r.affine <= in_item.affine_bottom_row;
      for (int i = 0; i < 9; i++) begin
        s0_sq_r[i] <= 64'(mag_c[i]) * 64'(mag_c[i]);
      end
    end
  end

  // column sums, then one square root digit per stage
  always_comb begin
    logic [63:0] bitv;
    vld_nxt     = {vld_r[SQRT_STEPS-1:0], s0_vld_r};
    info_nxt[0] = s0_info_r;
    for (int c = 0; c < 3; c++) begin
      x_nxt[0][c]   = s0_sq_r[c] + s0_sq_r[3+c] + s0_sq_r[6+c];
      res_nxt[0][c] = '0;
    end
    for (int k = 0; k < SQRT_STEPS; k++) begin
      bitv          = 64'd1 << (62 - 2 * k);
      info_nxt[k+1] = info_r[k];
      for (int c = 0; c < 3; c++) begin
        if (x_r[k][c] >= res_r[k][c] + bitv) begin
          x_nxt[k+1][c]   = x_r[k][c] - (res_r[k][c] + bitv);
          res_nxt[k+1][c] = (res_r[k][c] >> 1) + bitv;
        end else begin
          x_nxt[k+1][c]   = x_r[k][c];
          res_nxt[k+1][c] = res_r[k][c] >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= SQRT_STEPS; k++) begin
        info_r[k] <= info_nxt[k];
        x_r[k]    <= x_nxt[k];
        res_r[k]  <= res_nxt[k];
      end
    end
  end

  always_comb begin
    out_vld       = vld_r[SQRT_STEPS];
    out_item.info = info_r[SQRT_STEPS];
    for (int c = 0; c < 3; c++) begin
      out_item.norm[c] = res_r[SQRT_STEPS][c][DATA_W-1:0];
    end
  end

endmodule

// File: sv/nm3i_ndiv.sv
module nm3i_ndiv import nm3i_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_vld,
  input  norm_item_t in_item,
  output logic       out_vld,
  output ndiv_item_t out_item
);

  typedef struct packed {
    logic [2:0][DATA_W-1:0] norm;
    logic [8:0]             neg;
    logic                   affine;
    logic                   zero;
  } nd_info_t;

  logic [ND_STEPS:0] vld_r;
  logic [ND_STEPS:0] vld_nxt;
  nd_info_t          info_r   [ND_STEPS+1];
  nd_info_t          info_nxt [ND_STEPS+1];
  div_t              div_r    [ND_STEPS+1][9];
  div_t              div_nxt  [ND_STEPS+1][9];
  logic [DATA_W-1:0] qm;

  // setup, then one quotient bit per stage of m * 2^30 / norm
  always_comb begin
    vld_nxt            = {vld_r[ND_STEPS-1:0], in_vld};
    info_nxt[0].norm   = in_item.norm;
    info_nxt[0].neg    = in_item.info.neg;
    info_nxt[0].affine = in_item.info.affine;
    info_nxt[0].zero   = (in_item.norm[0] == '0) || (in_item.norm[1] == '0) ||
                         (in_item.norm[2] == '0);
    for (int i = 0; i < 9; i++) begin
      div_nxt[0][i].dv  = 64'(in_item.info.mag[i]) << NORM_FRAC;
      div_nxt[0][i].rem = div_nxt[0][i].dv >> ND_STEPS;
      div_nxt[0][i].q   = '0;
    end
    for (int k = 0; k < ND_STEPS; k++) begin
      info_nxt[k+1] = info_r[k];
      for (int i = 0; i < 9; i++) begin
        div_nxt[k+1][i] = div_step(div_r[k][i], 64'(info_r[k].norm[i % 3]),
                                   div_r[k][i].dv[ND_STEPS-1-k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= ND_STEPS; k++) begin
        info_r[k] <= info_nxt[k];
        for (int i = 0; i < 9; i++) begin
          div_r[k][i] <= div_nxt[k][i];
        end
      end
    end
  end

  // signed normalized entries
  always_comb begin
    qm              = '0;
    out_vld         = vld_r[ND_STEPS];
    out_item.norm   = info_r[ND_STEPS].norm;
    out_item.affine = info_r[ND_STEPS].affine;
    out_item.zero   = info_r[ND_STEPS].zero;
    for (int i = 0; i < 9; i++) begin
      qm            = DATA_W'(div_r[ND_STEPS][i].q[ND_STEPS-1:0]);
      out_item.a[i] = info_r[ND_STEPS].neg[i] ? (~qm + 1'b1) : qm;
    end
  end

endmodule

// File: sv/nm3i_adj.sv
module nm3i_adj import nm3i_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [THR_W-1:0] thresh,
  input  logic             in_vld,
  input  ndiv_item_t       in_item,
  output logic             out_vld,
  output adj_item_t        out_item
);

  typedef struct packed {
    logic [2:0][DATA_W-1:0] norm;
    logic                   affine;
    logic                   zero;
  } adj_ctl_t;

  logic [6:0]                vld_r;
  adj_ctl_t                  ctl_r [6];
  logic [8:0][DATA_W-1:0]    a_r   [3];

  logic signed [63:0]        pa_nxt  [9];
  logic signed [63:0]        pb_nxt  [9];
  logic signed [63:0]        pa_r    [9];
  logic signed [63:0]        pb_r    [9];
  logic signed [63:0]        diff_r  [9];
  logic [8:0][ADJ_W-1:0]     adj_nxt;
  logic [8:0][ADJ_W-1:0]     adj_r   [4];
  logic signed [63:0]        dp_nxt  [3];
  logic signed [63:0]        dp_r    [3];
  logic signed [63:0]        dsum_r;
  logic [DMAG_W-1:0]         dmag_nxt;
  logic [DMAG_W-1:0]         dmag_r;
  logic                      dneg_r;
  adj_item_t                 out_r;

  // magnitude after rounding half away from zero at the Q2.30 point
  function automatic logic [63:0] rnd_mag(input logic [63:0] v);
    logic [63:0] m;
    m = v[63] ? (~v + 64'd1) : v;
    return (m + (64'd1 << (NORM_FRAC - 1))) >> NORM_FRAC;
  endfunction

  // cofactor products
  always_comb begin
    pa_nxt[0] = $signed(in_item.a[4]) * $signed(in_item.a[8]);
    pb_nxt[0] = $signed(in_item.a[5]) * $signed(in_item.a[7]);
    pa_nxt[1] = $signed(in_item.a[2]) * $signed(in_item.a[7]);
    pb_nxt[1] = $signed(in_item.a[1]) * $signed(in_item.a[8]);
    pa_nxt[2] = $signed(in_item.a[1]) * $signed(in_item.a[5]);
    pb_nxt[2] = $signed(in_item.a[2]) * $signed(in_item.a[4]);
    pa_nxt[3] = $signed(in_item.a[5]) * $signed(in_item.a[6]);
    pb_nxt[3] = $signed(in_item.a[3]) * $signed(in_item.a[8]);
    pa_nxt[4] = $signed(in_item.a[0]) * $signed(in_item.a[8]);
    pb_nxt[4] = $signed(in_item.a[2]) * $signed(in_item.a[6]);
    pa_nxt[5] = $signed(in_item.a[2]) * $signed(in_item.a[3]);
    pb_nxt[5] = $signed(in_item.a[0]) * $signed(in_item.a[5]);
    pa_nxt[6] = $signed(in_item.a[3]) * $signed(in_item.a[7]);
    pb_nxt[6] = $signed(in_item.a[4]) * $signed(in_item.a[6]);
    pa_nxt[7] = $signed(in_item.a[1]) * $signed(in_item.a[6]);
    pb_nxt[7] = $signed(in_item.a[0]) * $signed(in_item.a[7]);
    pa_nxt[8] = $signed(in_item.a[0]) * $signed(in_item.a[4]);
    pb_nxt[8] = $signed(in_item.a[1]) * $signed(in_item.a[3]);
  end

  // rounded adjugate
  always_comb begin
    logic [63:0] mm;
    for (int k = 0; k < 9; k++) begin
      mm         = rnd_mag(diff_r[k]);
      adj_nxt[k] = ADJ_W'(diff_r[k][63] ? (~mm + 64'd1) : mm);
    end
  end

  // determinant terms along the first row
  always_comb begin
    dp_nxt[0] = $signed(a_r[2][0]) * $signed(adj_r[0][0]);
    dp_nxt[1] = $signed(a_r[2][1]) * $signed(adj_r[0][3]);
    dp_nxt[2] = $signed(a_r[2][2]) * $signed(adj_r[0][6]);
    dmag_nxt  = DMAG_W'(rnd_mag(dsum_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r[0] <= '{norm: in_item.norm, affine: in_item.affine, zero: in_item.zero};
      for (int s = 1; s < 6; s++) begin
        ctl_r[s] <= ctl_r[s-1];
      end
      a_r[0] <= in_item.a;
      a_r[1] <= a_r[0];
      a_r[2] <= a_r[1];
      for (int k = 0; k < 9; k++) begin
        pa_r[k]   <= pa_nxt[k];
        pb_r[k]   <= pb_nxt[k];
        diff_r[k] <= pa_r[k] - pb_r[k];
      end
      adj_r[0] <= adj_nxt;
      adj_r[1] <= adj_r[0];
      adj_r[2] <= adj_r[1];
      adj_r[3] <= adj_r[2];
      for (int j = 0; j < 3; j++) begin
        dp_r[j] <= dp_nxt[j];
      end
      dsum_r <= dp_r[0] + dp_r[1] + dp_r[2];
      dmag_r <= dmag_nxt;
      dneg_r <= dsum_r[63] && (dmag_nxt != '0);
      // singular check against the threshold
      out_r.adj      <= adj_r[3];
      out_r.dneg     <= dneg_r;
      out_r.dmag     <= dmag_r;
      out_r.norm     <= ctl_r[5].norm;
      out_r.affine   <= ctl_r[5].affine;
      out_r.zero     <= ctl_r[5].zero;
      out_r.singular <= dmag_r <= DMAG_W'(thresh);
    end
  end

  assign out_vld  = vld_r[6];
  assign out_item = out_r;

endmodule

// File: sv/nm3i_scale.sv
module nm3i_scale import nm3i_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_vld,
  input  adj_item_t in_item,
  output logic      out_vld,
  output out_item_t out_item
);

  typedef struct packed {
    logic [2:0][DATA_W-1:0] norm;
    logic [DMAG_W-1:0]      dmag;
    logic [8:0]             neg;
    logic [8:0]             over;
    logic                   affine;
    logic                   zero;
    logic                   singular;
  } sc_info_t;

  logic [SC_LAST:0]           vld_r;
  logic [SC_LAST:0]           vld_nxt;
  sc_info_t                   info_r   [SC_LAST+1];
  sc_info_t                   info_nxt [SC_LAST+1];
  div_t                       div_r    [SC_LAST+1][9];
  div_t                       div_nxt  [SC_LAST+1][9];
  logic [ADJ_W-1:0]           am_c     [9];
  logic [8:0][DATA_W-1:0]     inv_c;
  logic [8:0]                 sat_c;
  logic [2:0]                 status_c;
  logic                       out_vld_r;
  out_item_t                  out_r;

  always_comb begin
    vld_nxt = {vld_r[SC_LAST-1:0], in_vld};

    // adj * 2^16 / |det|
    info_nxt[0].norm     = in_item.norm;
    info_nxt[0].dmag     = in_item.dmag;
    info_nxt[0].over     = '0;
    info_nxt[0].affine   = in_item.affine;
    info_nxt[0].zero     = in_item.zero;
    info_nxt[0].singular = in_item.singular;
    for (int i = 0; i < 9; i++) begin
      info_nxt[0].neg[i] = in_item.adj[i][ADJ_W-1] ^ in_item.dneg;
      am_c[i] = in_item.adj[i][ADJ_W-1] ? (~in_item.adj[i] + 1'b1) : in_item.adj[i];
      div_nxt[0][i].dv  = 64'(am_c[i]) << FRAC_W;
      div_nxt[0][i].rem = div_nxt[0][i].dv >> T_STEPS;
      div_nxt[0][i].q   = '0;
    end
    for (int k = 0; k < T_STEPS; k++) begin
      info_nxt[k+1] = info_r[k];
      for (int i = 0; i < 9; i++) begin
        div_nxt[k+1][i] = div_step(div_r[k][i], 64'(info_r[k].dmag),
                                   div_r[k][i].dv[T_STEPS-1-k]);
      end
    end

    // t * 2^16 / input column norm (one per output row), quotient limited to the output width
    info_nxt[T_STEPS+1] = info_r[T_STEPS];
    for (int i = 0; i < 9; i++) begin
      div_nxt[T_STEPS+1][i].dv  = 64'(div_r[T_STEPS][i].q) << FRAC_W;
      div_nxt[T_STEPS+1][i].rem = div_nxt[T_STEPS+1][i].dv >> Q_STEPS;
      div_nxt[T_STEPS+1][i].q   = '0;
      info_nxt[T_STEPS+1].over[i] =
        div_nxt[T_STEPS+1][i].rem >= 64'(info_r[T_STEPS].norm[i / 3]);
    end
    for (int k = 0; k < Q_STEPS; k++) begin
      info_nxt[T_STEPS+2+k] = info_r[T_STEPS+1+k];
      for (int i = 0; i < 9; i++) begin
        div_nxt[T_STEPS+2+k][i] = div_step(div_r[T_STEPS+1+k][i],
                                           64'(info_r[T_STEPS+1+k].norm[i / 3]),
                                           div_r[T_STEPS+1+k][i].dv[Q_STEPS-1-k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= SC_LAST; k++) begin
        info_r[k] <= info_nxt[k];
        for (int i = 0; i < 9; i++) begin
          div_r[k][i] <= div_nxt[k][i];
        end
      end
    end
  end

  // saturation, sign and status
  always_comb begin
    logic [DATA_W-1:0] qv;
    logic [DATA_W-1:0] lim;
    logic [DATA_W-1:0] mq;
    for (int i = 0; i < 9; i++) begin
      qv       = DATA_W'(div_r[SC_LAST][i].q[Q_STEPS-1:0]);
      lim      = info_r[SC_LAST].neg[i] ? NEG_LIM : POS_LIM;
      sat_c[i] = info_r[SC_LAST].over[i] || (qv > lim);
      mq       = sat_c[i] ? lim : qv;
      inv_c[i] = info_r[SC_LAST].neg[i] ? (~mq + 1'b1) : mq;
    end
    if (!info_r[SC_LAST].affine) begin
      status_c = ST_NOT_AFFINE;
    end else if (info_r[SC_LAST].zero) begin
      status_c = ST_ZERO_COL;
    end else if (info_r[SC_LAST].singular) begin
      status_c = ST_SINGULAR;
    end else if (|sat_c) begin
      status_c = ST_SAT;
    end else begin
      status_c = ST_OK;
    end
    if (status_c == ST_NOT_AFFINE || status_c == ST_ZERO_COL ||
        status_c == ST_SINGULAR) begin
      inv_c = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[SC_LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.inv00  <= inv_c[0];
      out_r.inv01  <= inv_c[1];
      out_r.inv02  <= inv_c[2];
      out_r.inv10  <= inv_c[3];
      out_r.inv11  <= inv_c[4];
      out_r.inv12  <= inv_c[5];
      out_r.inv20  <= inv_c[6];
      out_r.inv21  <= inv_c[7];
      out_r.inv22  <= inv_c[8];
      out_r.status <= status_c;
    end
  end

  assign out_vld  = out_vld_r;
  assign out_item = out_r;

endmodule

// File: sv/normalized_matrix3_inverse.sv
// 3x3 inverse of the linear part of an affine matrix, signed Q16.16.
// Input channel: in_valid / in_stall carry one matrix per beat in in_data
// (nine entries plus the affine bottom-row flag). Output channel:
// out_valid / out_stall carry the nine inverse entries and a status code.
// Configuration: cfg_valid / cfg_ready write the 31-bit singular
// threshold; cfg_ready is always high. Write it only while no matrix is
// in flight.
// Throughput: one matrix per cycle while the output is not stalled. The
// pipeline holds the one-bit-per-stage square root (32 stages),
// the three restoring dividers (31, 48 and 32 stages) and the
// multiply/round stages of the adjugate and determinant.
// A stalled output beat holds the whole pipeline: in_stall rises in the
// same cycle and nothing is lost or repeated; bubbles travel as invalid.
// Reset (rst_n low, synchronous) empties the pipeline and sets the
// threshold to zero, so only a determinant that rounds to zero is singular.
module normalized_matrix3_inverse import nm3i_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [THR_W-1:0] cfg_data
);

  logic             en;
  logic [THR_W-1:0] thresh_r;
  logic             nrm_vld;
  norm_item_t       nrm_item;
  logic             nd_vld;
  ndiv_item_t       nd_item;
  logic             adj_vld;
  adj_item_t        adj_item;

  // pipeline advances unless the output beat is held
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      thresh_r <= cfg_data;
    end
  end

  nm3i_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .in_item  (in_data),
    .out_vld  (nrm_vld),
    .out_item (nrm_item)
  );

  nm3i_ndiv u_ndiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (nrm_vld),
    .in_item  (nrm_item),
    .out_vld  (nd_vld),
    .out_item (nd_item)
  );

  nm3i_adj u_adj (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .thresh   (thresh_r),
    .in_vld   (nd_vld),
    .in_item  (nd_item),
    .out_vld  (adj_vld),
    .out_item (adj_item)
  );

  nm3i_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (adj_vld),
    .in_item  (adj_item),
    .out_vld  (out_valid),
    .out_item (out_data)
  );

endmodule
